// ===== rtl/refcounted_cache_evictor_unit_assert.svh =====
`ifndef REFCOUNTED_CACHE_EVICTOR_UNIT_ASSERT_SVH
`define REFCOUNTED_CACHE_EVICTOR_UNIT_ASSERT_SVH

// implication checks, same cycle and next cycle
`define RCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rce_pkg.sv =====
package rce_pkg;

    localparam int IDXW = 10;
    localparam int SUMW = 35;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_GET     = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_INVAL   = 3'd3;
    localparam logic [2:0] CMD_CLEANUP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic REG_CACHE_LIMIT  = 1'b0;
    localparam logic REG_MIN_IDLE_AGE = 1'b1;

    localparam logic [28:0] CACHE_LIMIT_RESET = 29'd8388608;
    localparam logic [7:0]  IDLE_AGE_RESET    = 8'd5;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_GET   = 3'd1,
        OP_INC   = 3'd2,
        OP_REL   = 3'd3,
        OP_INV   = 3'd4,
        OP_PURGE = 3'd5,
        OP_EVICT = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] lookup_key;
        logic [23:0] entry_size;
        logic [4:0]  entry_index;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot_index;
        logic [15:0] ref_count_out;
        logic [28:0] bytes_in_use;
        logic [18:0] kib_in_use;
        logic [5:0]  evicted_count;
    } t_rsp;

    // token walking the cell chain
    typedef struct packed {
        logic            vld;
        t_op             op;
        logic [31:0]     key;
        logic [31:0]     now;
        logic [23:0]     size;
        logic [IDXW-1:0] idx;
        logic            kill;
        logic            srch;
        logic            hit;
        logic [IDXW-1:0] pick;
        logic [31:0]     age;
        logic [31:0]     la;
        logic [23:0]     bytes;
        logic [15:0]     rc;
        logic [SUMW-1:0] sum;
        logic [IDXW:0]   cnt;
        logic [31:0]     order;
    } t_tok;

endpackage

// ===== rtl/refcounted_cache_evictor_unit.sv =====
// Reference-counted cache table, one request at a time. Each slot lives in a cell of a chain.
// A request sends a token down the chain, one cell per cycle, to the decision at its end.
// Add, release and invalidate take one pass, and get takes two on a hit. Cleanup takes a
// sweep pass. When the byte total is then over the limit, it takes one pass per evicted
// entry and one closing pass, and each of these passes is launched from a decision state.
// With the total within the limit, cleanup goes from the decision state to the output.
// Every request then loads the output register and returns to idle.
// A finished response waits in an output register while the next request is taken.
module refcounted_cache_evictor_unit #(
    parameter int ENTRIES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rce_pkg::t_req i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output rce_pkg::t_rsp o_out_data,
    input  logic          i_out_stall,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [28:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WAIT = 4'b0010,
        S_EVAL = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [28:0] r_limit;
    logic [7:0]  r_mia;
    logic [31:0] r_order, n_order;
    rce_pkg::t_req r_req, n_req;
    rce_pkg::t_op  r_op, n_op;
    logic [rce_pkg::SUMW-1:0] r_mem, n_mem;
    logic [rce_pkg::IDXW:0]   r_ev, n_ev;
    logic r_killv, n_killv;
    logic [rce_pkg::IDXW-1:0] r_kill, n_kill;
    rce_pkg::t_rsp r_res, n_res;
    rce_pkg::t_tok r_go, n_go;
    logic r_ovalid, n_ovalid;
    rce_pkg::t_rsp r_out, n_out;

    rce_pkg::t_tok w_chain [ENTRIES+1];
    rce_pkg::t_tok w_end;
    logic w_acc;

    assign w_chain[0] = r_go;
    assign w_end = w_chain[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        rce_cell #(.ID(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_chain[g]),
            .o_tok  (w_chain[g+1])
        );
    end

    function automatic rce_pkg::t_rsp clean_rsp(logic [rce_pkg::SUMW-1:0] mem,
                                                logic [rce_pkg::IDXW:0] ev);
        rce_pkg::t_rsp r;
        logic [rce_pkg::SUMW-11:0] kib;
        r   = '0;
        kib = mem[rce_pkg::SUMW-1:10];
        r.status = rce_pkg::ST_OK;
        r.bytes_in_use  = (mem > rce_pkg::SUMW'(29'h1FFFFFFF)) ? 29'h1FFFFFFF : mem[28:0];
        r.kib_in_use    = (kib > (rce_pkg::SUMW-10)'(19'h7FFFF)) ? 19'h7FFFF : kib[18:0];
        r.evicted_count = (ev > (rce_pkg::IDXW+1)'(63)) ? 6'd63 : ev[5:0];
        return r;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc = i_in_valid && !o_in_stall;

    always_comb begin
        n_state  = r_state;
        n_order  = r_order;
        n_req    = r_req;
        n_op     = r_op;
        n_mem    = r_mem;
        n_ev     = r_ev;
        n_killv  = r_killv;
        n_kill   = r_kill;
        n_res    = r_res;
        n_ovalid = r_ovalid && i_out_stall;
        n_out    = r_out;
        n_go       = '0;
        n_go.key   = r_req.lookup_key;
        n_go.now   = r_req.now_seconds;
        n_go.size  = r_req.entry_size;
        n_go.idx   = rce_pkg::IDXW'(r_req.entry_index);
        n_go.order = r_order;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_req      = i_in_data;
                    n_go.key   = i_in_data.lookup_key;
                    n_go.now   = i_in_data.now_seconds;
                    n_go.size  = i_in_data.entry_size;
                    n_go.idx   = rce_pkg::IDXW'(i_in_data.entry_index);
                    n_go.vld   = 1'b1;
                    n_state    = S_WAIT;
                    n_mem      = '0;
                    n_ev       = '0;
                    n_killv    = 1'b0;
                    case (i_in_data.command)
                        rce_pkg::CMD_ADD:     n_go.op = rce_pkg::OP_ADD;
                        rce_pkg::CMD_GET:     n_go.op = rce_pkg::OP_GET;
                        rce_pkg::CMD_RELEASE: n_go.op = rce_pkg::OP_REL;
                        rce_pkg::CMD_INVAL:   n_go.op = rce_pkg::OP_INV;
                        rce_pkg::CMD_CLEANUP: n_go.op = rce_pkg::OP_PURGE;
                        default: begin
                            n_go.vld     = 1'b0;
                            n_res        = '0;
                            n_res.status = rce_pkg::ST_BAD;
                            n_state      = S_FIN;
                        end
                    endcase
                    n_op = n_go.op;
                end
            end
            S_WAIT: begin
                if (w_end.vld) begin
                    n_res   = '0;
                    n_state = S_FIN;
                    case (r_op)
                        rce_pkg::OP_ADD: begin
                            if (w_end.hit) begin
                                n_res.status        = rce_pkg::ST_OK;
                                n_res.slot_index    = w_end.pick[4:0];
                                n_res.ref_count_out = 16'd1;
                                n_order             = r_order + 32'd1;
                            end else begin
                                n_res.status = rce_pkg::ST_FULL;
                            end
                        end
                        rce_pkg::OP_GET: begin
                            if (w_end.hit) begin
                                n_go.vld = 1'b1;
                                n_go.op  = rce_pkg::OP_INC;
                                n_go.idx = w_end.pick;
                                n_op     = rce_pkg::OP_INC;
                                n_state  = S_WAIT;
                            end else begin
                                n_res.status = rce_pkg::ST_MISS;
                            end
                        end
                        rce_pkg::OP_INC, rce_pkg::OP_REL, rce_pkg::OP_INV: begin
                            n_res.slot_index = w_end.idx[4:0];
                            if (w_end.hit) begin
                                n_res.status        = rce_pkg::ST_OK;
                                n_res.ref_count_out = w_end.rc;
                            end else begin
                                n_res.status = rce_pkg::ST_BAD;
                            end
                        end
                        rce_pkg::OP_PURGE: begin
                            n_mem   = w_end.sum;
                            n_ev    = w_end.cnt;
                            n_state = S_EVAL;
                        end
                        rce_pkg::OP_EVICT: begin
                            n_killv = 1'b0;
                            if (w_end.hit) begin
                                n_mem   = r_mem - rce_pkg::SUMW'(w_end.bytes);
                                n_ev    = r_ev + 1'b1;
                                n_killv = 1'b1;
                                n_kill  = w_end.pick;
                                n_state = S_EVAL;
                            end else begin
                                n_res = clean_rsp(r_mem, r_ev);
                            end
                        end
                        default: begin
                            n_res.status = rce_pkg::ST_BAD;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                if (r_mem > rce_pkg::SUMW'(r_limit) || r_killv) begin
                    n_go.vld  = 1'b1;
                    n_go.op   = rce_pkg::OP_EVICT;
                    n_go.kill = r_killv;
                    n_go.idx  = r_kill;
                    n_go.now  = r_req.now_seconds - 32'(r_mia);
                    n_go.srch = (r_mem > rce_pkg::SUMW'(r_limit)) &&
                                (r_req.now_seconds >= 32'(r_mia));
                    n_op      = rce_pkg::OP_EVICT;
                    n_state   = S_WAIT;
                end else begin
                    n_res   = clean_rsp(r_mem, r_ev);
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= rce_pkg::CACHE_LIMIT_RESET;
            r_mia    <= rce_pkg::IDLE_AGE_RESET;
            r_order  <= '0;
            r_go.vld <= 1'b0;
            r_ovalid <= 1'b0;
            r_killv  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_order  <= n_order;
            r_go     <= n_go;
            r_ovalid <= n_ovalid;
            r_killv  <= n_killv;
            if (i_cfg_we) begin
                if (i_cfg_index == rce_pkg::REG_CACHE_LIMIT) r_limit <= i_cfg_data;
                else r_mia <= i_cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_op   <= n_op;
        r_mem  <= n_mem;
        r_ev   <= n_ev;
        r_kill <= n_kill;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `include "refcounted_cache_evictor_unit_assert.svh"

    `RCE_ASSERT_NXT(a_busy_after_req, w_acc, o_in_stall, "request taken but block not busy")
    `RCE_ASSERT_IMP(a_token_only_in_wait, w_end.vld, r_state == S_WAIT, "stray chain token")
    `RCE_ASSERT_IMP(a_ev_bound, r_state == S_EVAL, r_ev <= (rce_pkg::IDXW+1)'(ENTRIES),
                    "eviction count exceeds table size")

endmodule

// ===== rtl/rce_cell.sv =====
module rce_cell #(
    parameter int ID = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rce_pkg::t_tok i_tok,
    output rce_pkg::t_tok o_tok
);

    logic        r_valid, n_valid;
    logic        r_stale, n_stale;
    logic [31:0] r_key, n_key;
    logic [15:0] r_rc, n_rc;
    logic [31:0] r_la, n_la;
    logic [23:0] r_bytes, n_bytes;
    logic [31:0] r_io, n_io;
    rce_pkg::t_tok r_tok, n_tok;

    logic [31:0] w_age;
    logic        w_me;

    assign w_age = i_tok.order - r_io;
    assign w_me  = (i_tok.idx == rce_pkg::IDXW'(ID));

    always_comb begin
        n_valid = r_valid;
        n_stale = r_stale;
        n_key   = r_key;
        n_rc    = r_rc;
        n_la    = r_la;
        n_bytes = r_bytes;
        n_io    = r_io;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            case (i_tok.op)
                rce_pkg::OP_ADD: begin
                    if (!i_tok.hit && !r_valid) begin
                        n_valid    = 1'b1;
                        n_stale    = 1'b0;
                        n_key      = i_tok.key;
                        n_rc       = 16'd1;
                        n_la       = i_tok.now;
                        n_bytes    = i_tok.size;
                        n_io       = i_tok.order;
                        n_tok.hit  = 1'b1;
                        n_tok.pick = rce_pkg::IDXW'(ID);
                    end
                end
                rce_pkg::OP_GET: begin
                    if (r_valid && !r_stale && r_key == i_tok.key &&
                        (!i_tok.hit || w_age > i_tok.age)) begin
                        n_tok.hit  = 1'b1;
                        n_tok.pick = rce_pkg::IDXW'(ID);
                        n_tok.age  = w_age;
                    end
                end
                rce_pkg::OP_INC, rce_pkg::OP_REL, rce_pkg::OP_INV: begin
                    if (w_me && r_valid) begin
                        n_tok.hit = 1'b1;
                        if (i_tok.op == rce_pkg::OP_INC) begin
                            if (r_rc != 16'hFFFF) n_rc = r_rc + 16'd1;
                        end else if (i_tok.op == rce_pkg::OP_REL) begin
                            if (r_rc != 16'd0) n_rc = r_rc - 16'd1;
                            n_la = i_tok.now;
                        end else begin
                            n_stale = 1'b1;
                        end
                        n_tok.rc = n_rc;
                    end
                end
                rce_pkg::OP_PURGE: begin
                    if (r_valid && r_stale && r_rc == 16'd0) begin
                        n_valid   = 1'b0;
                        n_tok.cnt = i_tok.cnt + 1'b1;
                    end else if (r_valid) begin
                        n_tok.sum = i_tok.sum + rce_pkg::SUMW'(r_bytes);
                    end
                end
                rce_pkg::OP_EVICT: begin
                    if (i_tok.kill && w_me) begin
                        n_valid = 1'b0;
                    end else if (i_tok.srch && r_valid && r_rc == 16'd0 &&
                                 r_la < i_tok.now &&
                                 (!i_tok.hit || r_la < i_tok.la ||
                                  (r_la == i_tok.la && w_age > i_tok.age))) begin
                        n_tok.hit   = 1'b1;
                        n_tok.pick  = rce_pkg::IDXW'(ID);
                        n_tok.la    = r_la;
                        n_tok.age   = w_age;
                        n_tok.bytes = r_bytes;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_stale   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_stale <= n_stale;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_rc    <= n_rc;
        r_la    <= n_la;
        r_bytes <= n_bytes;
        r_io    <= n_io;
    end

    assign o_tok = r_tok;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;
    localparam int WATCHDOG = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    rce_pkg::t_req i_in_data = '0;
    logic o_in_stall;
    logic o_out_valid;
    rce_pkg::t_rsp o_out_data;
    logic i_out_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [28:0] i_cfg_data = '0;

    refcounted_cache_evictor_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // shadow copy of the cache table
    logic [28:0] lim;
    logic [7:0]  idle_min;
    logic        sv_valid [NSLOT];
    logic        sv_stale [NSLOT];
    logic [31:0] sv_key [NSLOT];
    logic [15:0] sv_rc [NSLOT];
    logic [31:0] sv_la [NSLOT];
    logic [23:0] sv_bytes [NSLOT];
    logic [31:0] sv_ord [NSLOT];
    logic [31:0] ord_next;
    logic [31:0] clock_s;

    rce_pkg::t_rsp rsp_q[$];
    int errors = 0;
    int idle_cycles = 0;
    logic long_stall = 0;

    function automatic rce_pkg::t_rsp cache_predict(rce_pkg::t_req r);
        rce_pkg::t_rsp o;
        int pick;
        logic [35:0] mem;
        longint thr;
        int ev;
        o = '0;
        pick = -1;
        mem = 0;
        ev = 0;
        case (r.command)
            rce_pkg::CMD_ADD: begin
                for (int s = 0; s < NSLOT; s++) if (!sv_valid[s] && pick < 0) pick = s;
                if (pick < 0) begin
                    o.status = rce_pkg::ST_FULL;
                end else begin
                    sv_valid[pick] = 1'b1; sv_stale[pick] = 1'b0; sv_key[pick] = r.lookup_key;
                    sv_rc[pick] = 16'd1; sv_la[pick] = r.now_seconds;
                    sv_bytes[pick] = r.entry_size; sv_ord[pick] = ord_next;
                    ord_next++;
                    o.status = rce_pkg::ST_OK; o.slot_index = 5'(pick);
                    o.ref_count_out = 16'd1;
                end
            end
            rce_pkg::CMD_GET: begin
                for (int s = 0; s < NSLOT; s++) begin
                    if (!sv_valid[s] || sv_stale[s] || sv_key[s] != r.lookup_key) continue;
                    if (pick < 0 || (ord_next - sv_ord[s]) > (ord_next - sv_ord[pick]))
                        pick = s;
                end
                if (pick < 0) begin
                    o.status = rce_pkg::ST_MISS;
                end else begin
                    if (sv_rc[pick] != 16'hFFFF) sv_rc[pick]++;
                    o.status = rce_pkg::ST_OK; o.slot_index = 5'(pick);
                    o.ref_count_out = sv_rc[pick];
                end
            end
            rce_pkg::CMD_RELEASE, rce_pkg::CMD_INVAL: begin
                o.slot_index = r.entry_index;
                if (!sv_valid[r.entry_index]) begin
                    o.status = rce_pkg::ST_BAD;
                end else begin
                    if (r.command == rce_pkg::CMD_RELEASE) begin
                        if (sv_rc[r.entry_index] != 16'd0) sv_rc[r.entry_index]--;
                        sv_la[r.entry_index] = r.now_seconds;
                    end else begin
                        sv_stale[r.entry_index] = 1'b1;
                    end
                    o.status = rce_pkg::ST_OK; o.ref_count_out = sv_rc[r.entry_index];
                end
            end
            rce_pkg::CMD_CLEANUP: begin
                for (int s = 0; s < NSLOT; s++)
                    if (sv_valid[s] && sv_stale[s] && sv_rc[s] == 16'd0) begin
                        sv_valid[s] = 1'b0; ev++;
                    end
                for (int s = 0; s < NSLOT; s++) if (sv_valid[s]) mem += 36'(sv_bytes[s]);
                thr = longint'(r.now_seconds) - longint'(idle_min);
                while (mem > 36'(lim)) begin
                    pick = -1;
                    for (int s = 0; s < NSLOT; s++) begin
                        if (!sv_valid[s] || sv_rc[s] != 16'd0) continue;
                        if (longint'(sv_la[s]) >= thr) continue;
                        if (pick < 0 || sv_la[s] < sv_la[pick] || (sv_la[s] == sv_la[pick]
                            && (ord_next - sv_ord[s]) > (ord_next - sv_ord[pick])))
                            pick = s;
                    end
                    if (pick < 0) break;
                    mem -= 36'(sv_bytes[pick]);
                    sv_valid[pick] = 1'b0;
                    ev++;
                end
                o.status = rce_pkg::ST_OK;
                o.bytes_in_use = (mem > 36'h1FFFFFFF) ? 29'h1FFFFFFF : mem[28:0];
                o.kib_in_use = ((mem >> 10) > 36'h7FFFF) ? 19'h7FFFF : mem[28:10];
                o.evicted_count = (ev > 63) ? 6'd63 : 6'(ev);
            end
            default: o.status = rce_pkg::ST_BAD;
        endcase
        return o;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(9) < 5) return 0;
        if ($urandom_range(19) == 0) return $urandom_range(80, 20);
        return $urandom_range(3);
    endfunction

    task automatic send_request(rce_pkg::t_req r);
        repeat (gap_len()) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rsp_q = {rsp_q, cache_predict(r)};
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        while (rsp_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [28:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rce_pkg::REG_CACHE_LIMIT) lim = val; else idle_min = val[7:0];
        @(posedge i_clk);
    endtask

    function automatic rce_pkg::t_req mk(logic [2:0] c, logic [31:0] k, logic [23:0] sz,
                                         logic [4:0] ix);
        rce_pkg::t_req r;
        r.command = c; r.lookup_key = k; r.entry_size = sz; r.entry_index = ix;
        r.now_seconds = clock_s;
        return r;
    endfunction

    task automatic test_directed();
        clock_s = 0;
        send_request(mk(rce_pkg::CMD_GET, 32'h0, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_RELEASE, 32'd0, 24'd0, 5'd31));
        send_request(mk(rce_pkg::CMD_INVAL, 32'd0, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_CLEANUP, 32'd0, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_ADD, 32'hFFFFFFFF, 24'hFFFFFF, 5'd0));
        send_request(mk(rce_pkg::CMD_ADD, 32'hFFFFFFFF, 24'h0, 5'd0));
        send_request(mk(rce_pkg::CMD_GET, 32'hFFFFFFFF, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_INVAL, 32'd0, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_GET, 32'hFFFFFFFF, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_RELEASE, 32'd0, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_RELEASE, 32'd0, 24'd0, 5'd0));
        send_request(mk(rce_pkg::CMD_RELEASE, 32'd0, 24'd0, 5'd0));
        clock_s = 3;
        send_request(mk(rce_pkg::CMD_CLEANUP, 32'd0, 24'd0, 5'd0));
        send_request(mk(3'd5, 32'd0, 24'd0, 5'd0));
        send_request(mk(3'd7, 32'hFFFFFFFF, 24'hFFFFFF, 5'd31));
        clock_s = 32'hFFFFFFFF;
        send_request(mk(rce_pkg::CMD_RELEASE, 32'd0, 24'd0, 5'd1));
        send_request(mk(rce_pkg::CMD_CLEANUP, 32'd0, 24'd0, 5'd0));
        wait_drain();
    endtask

    task automatic test_full_table();
        clock_s = 100;
        for (int i = 0; i < NSLOT + 2; i++)
            send_request(mk(rce_pkg::CMD_ADD, 32'($urandom_range(3)), 24'hFFFFFF, 5'd0));
        wait_drain();
        write_reg(rce_pkg::REG_CACHE_LIMIT, 29'h1FFFFFFF);
        send_request(mk(rce_pkg::CMD_CLEANUP, 32'd0, 24'd0, 5'd0));
        wait_drain();
        write_reg(rce_pkg::REG_CACHE_LIMIT, 29'd0);
        write_reg(rce_pkg::REG_MIN_IDLE_AGE, 29'd0);
        for (int i = 0; i < NSLOT; i++)
            send_request(mk(rce_pkg::CMD_RELEASE, 32'd0, 24'd0, 5'(i)));
        clock_s = 101;
        send_request(mk(rce_pkg::CMD_CLEANUP, 32'd0, 24'd0, 5'd0));
        wait_drain();
    endtask

    task automatic test_random(int n, logic [28:0] l, logic [7:0] a);
        rce_pkg::t_req r;
        int c;
        write_reg(rce_pkg::REG_CACHE_LIMIT, l);
        write_reg(rce_pkg::REG_MIN_IDLE_AGE, {21'd0, a});
        for (int i = 0; i < n; i++) begin
            clock_s = clock_s + 32'($urandom_range(4));
            c = $urandom_range(99);
            r.now_seconds = clock_s;
            r.lookup_key = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(7));
            r.entry_size = ($urandom_range(3) == 0) ? 24'($urandom()) :
                                                      24'($urandom_range(4000000));
            r.entry_index = 5'($urandom());
            if (c < 30) r.command = rce_pkg::CMD_ADD;
            else if (c < 50) r.command = rce_pkg::CMD_GET;
            else if (c < 75) r.command = rce_pkg::CMD_RELEASE;
            else if (c < 85) r.command = rce_pkg::CMD_INVAL;
            else if (c < 97) r.command = rce_pkg::CMD_CLEANUP;
            else r.command = 3'($urandom_range(7, 5));
            send_request(r);
            if (i == n / 2) wait_drain();
        end
        wait_drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if ($urandom_range(99) == 0) long_stall <= ~long_stall;
            i_out_stall <= long_stall ? ($urandom_range(9) != 0) : ($urandom_range(3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_q.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_out_data);
                errors++;
            end else begin
                rce_pkg::t_rsp e;
                e = rsp_q.pop_front();
                if (e.status != o_out_data.status || e.slot_index != o_out_data.slot_index
                    || e.ref_count_out != o_out_data.ref_count_out
                    || e.bytes_in_use != o_out_data.bytes_in_use
                    || e.kib_in_use != o_out_data.kib_in_use
                    || e.evicted_count != o_out_data.evicted_count) begin
                    $display("%0t: mismatch exp %p act %p", $time, e, o_out_data);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        lim = rce_pkg::CACHE_LIMIT_RESET;
        idle_min = rce_pkg::IDLE_AGE_RESET;
        for (int s = 0; s < NSLOT; s++) begin
            sv_valid[s] = 0; sv_stale[s] = 0; sv_key[s] = 0; sv_rc[s] = 0;
            sv_la[s] = 0; sv_bytes[s] = 0; sv_ord[s] = 0;
        end
        ord_next = 0;
        clock_s = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        clock_s = 1000;
        test_random(270, rce_pkg::CACHE_LIMIT_RESET, rce_pkg::IDLE_AGE_RESET);
        test_random(225, 29'd20000000, 8'd255);
        test_random(135, 29'd0, 8'd0);
        test_random(135, 29'h1FFFFFFF, 8'd2);
        wait_drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rce_pkg.sv
rtl/rce_cell.sv
rtl/refcounted_cache_evictor_unit.sv
verif/tb_top.sv
